>>> design/rcld_pkg.sv
// constants, defaults and helper functions of the repetition code letter decoder
// no dependencies; used by the channel interfaces and the decoder
package rcld_pkg;

    localparam int WORD_W           = 64;
    localparam int CHAR_W           = 7;
    localparam int INDEX_BITS       = 5;
    localparam int MAX_DISTANCE     = 4;
    localparam int KEPT_BITS        = 63;
    localparam int LETTER_BASE      = 97;
    localparam int UNKNOWN_CODE     = 63;
    localparam int DEF_REPEAT       = 9;
    localparam int DEF_SYMBOL_COUNT = 26;

    // number of bits of group i that fall below the top kept bit position
    function automatic int grp_len(input int i, input int repeat_n);
        int lo;
        int n;
        lo = i * repeat_n;
        n  = KEPT_BITS - lo;
        if (n < 0) begin
            n = 0;
        end
        if (n > repeat_n) begin
            n = repeat_n;
        end
        return n;
    endfunction

    // lowest word bit that must be clear for a match
    function automatic int valid_limit(input int repeat_n);
        int lim;
        lim = INDEX_BITS * repeat_n;
        if (lim > KEPT_BITS) begin
            lim = KEPT_BITS;
        end
        return lim;
    endfunction

endpackage

>>> design/rcld_if.sv
// valid/ready channel interfaces for received words and decoded letters
// depends on rcld_pkg for the field widths
interface rcld_in_if import rcld_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] received_word;

    modport source (output valid, output received_word, input ready);
    modport sink   (input valid, input received_word, output ready);
endinterface

interface rcld_out_if import rcld_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              matched;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output matched, output char_code, input ready);
    modport sink   (input valid, input matched, input char_code, output ready);
endinterface

>>> design/repetition_code_letter_decoder.sv
// throughput: one item per cycle; the three stages (group counts, letter distances,
//   highest-letter select) advance together and hold while the output is stalled
// reset: synchronous active low, clears the stage valid bits only
// depends on rcld_pkg and the channel interfaces in rcld_if.sv
module repetition_code_letter_decoder import rcld_pkg::*; #(
    parameter int REPEAT       = DEF_REPEAT,
    parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcld_in_if.sink    i_word,
    rcld_out_if.source o_result
);

    localparam int CNT_W   = $clog2(REPEAT + 1);
    localparam int DIST_W  = $clog2(INDEX_BITS * REPEAT + 1);
    localparam int VLIM    = valid_limit(REPEAT);
    localparam int SYM_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    typedef logic [CNT_W-1:0] t_cnt;

    // pipeline advances unless a finished result is held back
    logic w_adv;
    assign w_adv        = !o_result.valid || o_result.ready;
    assign i_word.ready = w_adv;

    // stage 1: ones count per group and out-of-range flag
    logic                    r_v1;
    t_cnt [INDEX_BITS-1:0]   r_cnt1, n_cnt1;
    logic                    r_oor1, n_oor1;

    always_comb begin
        int pos;
        n_oor1 = 1'b0;
        for (int b = VLIM; b < WORD_W; b++) begin
            n_oor1 = n_oor1 | i_word.received_word[b];
        end
        for (int i = 0; i < INDEX_BITS; i++) begin
            n_cnt1[i] = '0;
            for (int k = 0; k < REPEAT; k++) begin
                pos = i * REPEAT + k;
                if (pos < KEPT_BITS) begin
                    n_cnt1[i] = n_cnt1[i] + t_cnt'(i_word.received_word[pos]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_word.valid;
        end
        if (w_adv) begin
            r_cnt1 <= n_cnt1;
            r_oor1 <= n_oor1;
        end
    end

    // stage 2: distance to every letter codeword, compared against the limit
    logic                    r_v2;
    logic [SYMBOL_COUNT-1:0] r_hit2, n_hit2;

    always_comb begin
        logic [DIST_W-1:0] d;
        for (int r = 0; r < SYMBOL_COUNT; r++) begin
            d = '0;
            for (int i = 0; i < INDEX_BITS; i++) begin
                if (((r >> i) & 1) != 0) begin
                    d = d + DIST_W'(grp_len(i, REPEAT)) - DIST_W'(r_cnt1[i]);
                end else begin
                    d = d + DIST_W'(r_cnt1[i]);
                end
            end
            n_hit2[r] = !r_oor1 && (d <= DIST_W'(MAX_DISTANCE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
        if (w_adv) begin
            r_hit2 <= n_hit2;
        end
    end

    // stage 3: highest matching letter wins, result register
    logic              r_v3;
    logic              r_matched3, n_matched3;
    logic [CHAR_W-1:0] r_char3, n_char3;

    always_comb begin
        logic [SYM_W-1:0] letter;
        logic [7:0]       code;
        letter     = '0;
        n_matched3 = 1'b0;
        for (int r = 0; r < SYMBOL_COUNT; r++) begin
            if (r_hit2[r]) begin
                n_matched3 = 1'b1;
                letter     = SYM_W'(r);
            end
        end
        code    = 8'(LETTER_BASE) + 8'(letter);
        n_char3 = n_matched3 ? code[CHAR_W-1:0] : CHAR_W'(UNKNOWN_CODE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
        if (w_adv) begin
            r_matched3 <= n_matched3;
            r_char3    <= n_char3;
        end
    end

    assign o_result.valid     = r_v3;
    assign o_result.matched   = r_matched3;
    assign o_result.char_code = r_char3;

    // an out-of-range word never yields a letter hit
    a_oor_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_oor1 && w_adv) |=> (r_hit2 == '0))
        else $error("out-of-range word produced a letter hit");

    // an unmatched result always carries the unknown code
    a_unknown_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_matched3) |-> (r_char3 == CHAR_W'(UNKNOWN_CODE)))
        else $error("unmatched result without unknown code");

    // a matched result never carries the unknown code
    a_match_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_matched3) |-> (r_char3 != CHAR_W'(UNKNOWN_CODE)))
        else $error("matched result carries unknown code");

    // a held stage keeps its valid bit while the output stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> ($stable(r_v2) && $stable(r_v1)))
        else $error("pipeline moved during a stall");

endmodule
